// File: design/life_automaton_generation_macros.svh
// Assertion macros shared by the life generation block.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef LIFE_AUTOMATON_GENERATION_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define LAG_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define LAG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LAG_ASSERT_NOW(name, clk, rst_n, ante, cons, msg)
`define LAG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/lag_pkg.sv
`timescale 1ns / 1ps

package lag_pkg;

    // Grid limits and derived widths.
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned WDIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HDIM_W     = $clog2(MAX_HEIGHT + 1);

    // Fixed field widths of the ports.
    localparam int unsigned CFG_W      = 11;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned COORD_W    = 10;
    localparam int unsigned CFG_RESET  = 1024;

    // Window geometry: three columns of three rows, centre in the middle.
    localparam int unsigned COL_BITS   = 3;
    localparam int unsigned WIN_COLS   = 3;
    localparam int unsigned WIN_BITS   = COL_BITS * WIN_COLS;
    localparam int unsigned CENTER_BIT = 4;
    localparam int unsigned CNT_W      = $clog2(WIN_BITS);

    // Life rule counts.
    localparam int unsigned BIRTH_COUNT   = 3;
    localparam int unsigned SURVIVE_COUNT = 2;

    // Results that one input cell can release.
    localparam int unsigned RES_SLOTS  = 4;
    localparam int unsigned SLOT_W     = $clog2(RES_SLOTS);

    // Row store word: older row in the high bit, newer row in the low bit.
    localparam int unsigned STORE_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic               alive;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [RES_SLOTS-1:0]    mask;
        t_result [RES_SLOTS-1:0] slot;
    } t_result_set;

    // Next state of the centre cell of a 3x3 window.
    function automatic logic life_next(input logic [WIN_BITS-1:0] w);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < WIN_BITS; k++) begin
            if (k != CENTER_BIT) begin
                n = n + CNT_W'(w[k]);
            end
        end
        return (n == CNT_W'(BIRTH_COUNT)) ||
               ((n == CNT_W'(SURVIVE_COUNT)) && w[CENTER_BIT]);
    endfunction

    // A dimension of zero acts as one, and one above the limit as the limit.
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned maxv);
        int unsigned d;
        d = 32'(v);
        if (d == 0) begin
            d = 1;
        end else if (d > maxv) begin
            d = maxv;
        end
        return d;
    endfunction

endpackage

// File: design/lag_ram.sv
`timescale 1ns / 1ps

module lag_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; a read at the written
    // address returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lag_cell.sv
`timescale 1ns / 1ps

module lag_cell import lag_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic                i_clear,
    input  logic [COL_BITS-1:0] i_col,
    output logic [COL_BITS-1:0] o_col
);

    logic [COL_BITS-1:0] r_col;
    logic [COL_BITS-1:0] n_col;

    // On a shift the cell takes its right neighbor's column, or clears at
    // the start of a row so that nothing left of column 0 is seen.
    always_comb begin
        n_col = r_col;
        if (i_shift) begin
            n_col = i_clear ? '0 : i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

// File: design/lag_result_buf.sv
`timescale 1ns / 1ps

module lag_result_buf import lag_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result_set i_set,
    output logic        o_can_take,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    logic [RES_SLOTS-1:0]    r_mask;
    logic [RES_SLOTS-1:0]    n_mask;
    t_result [RES_SLOTS-1:0] r_slot;
    logic [SLOT_W-1:0]       head;
    logic                    pop;
    logic                    one_left;

    // The lowest pending slot goes out first, which keeps raster order.
    always_comb begin
        head = '0;
        for (int k = RES_SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                head = SLOT_W'(k);
            end
        end
    end

    assign o_valid  = |r_mask;
    assign pop      = o_valid && i_ready;
    assign one_left = (r_mask & (r_mask - RES_SLOTS'(1))) == '0;

    // A new set may enter once the last pending result leaves this cycle.
    assign o_can_take = (r_mask == '0) || (one_left && i_ready);

    always_comb begin
        n_mask = r_mask;
        if (i_push) begin
            n_mask = i_set.mask;
        end else if (pop) begin
            n_mask = r_mask & ~(RES_SLOTS'(1) << head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot <= i_set.slot;
        end
    end

    assign o_result = r_slot[head];

endmodule

// File: design/life_automaton_generation.sv
`timescale 1ns / 1ps
`include "life_automaton_generation_macros.svh"

// Channel   | Handshake                  | Payload
// ----------+----------------------------+-----------------------------------------------
// cell in   | i_valid / o_ready          | i_cell_alive
// result    | o_valid / i_ready          | o_next_alive o_cell_col o_cell_row o_gen_last
// config    | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// One cell request is taken per cycle unless o_ready is low. A request is registered in
// stage 1 and stage 2, its results in the result buffer. Results leave one per cycle while
// i_ready is high, so a request releasing k > 1 results holds back the input until they have
// left: k is two at a row end and in the last row and four at the frame end, fewer in
// column 0 or row 0. Reset (synchronous, active low) sets both dimensions to 1024 and the
// position to row 0, column 0. A stalled i_ready backs up to o_ready.
module life_automaton_generation import lag_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Cell requests.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cell_alive,
    // Results.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_next_alive,
    output logic [COORD_W-1:0]   o_cell_col,
    output logic [COORD_W-1:0]   o_cell_row,
    output logic                 o_gen_last,
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration, held already clamped.
    logic [WDIM_W-1:0] r_width;
    logic [HDIM_W-1:0] r_height;

    // Position of the next input cell.
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic accept;
    logic last_col_in;
    logic last_row_in;

    // Stage 1: row store data arrives.
    logic               r_s1_valid;
    logic               r_s1_cur;
    logic [COL_W-1:0]   r_s1_col;
    logic [ROW_W-1:0]   r_s1_row;
    logic               r_s1_first_col;
    logic               r_s1_last_col;
    logic               r_s1_last_row;
    logic               r_s1_has_top;
    logic               r_s1_has_mid;
    logic               s1_adv;

    // Row store forwarding for a read that met a write at the same address.
    logic               r_fwd_hit;
    logic [STORE_W-1:0] r_fwd_word;
    logic [STORE_W-1:0] ram_q;
    logic [STORE_W-1:0] store_word;
    logic [STORE_W-1:0] store_wdata;
    logic               top_bit;
    logic               mid_bit;

    // Window cell chain.
    logic [COL_BITS-1:0] win_col [WIN_COLS + 1];
    logic [WIN_BITS-1:0] window;

    // Stage 2: rule evaluation.
    logic               r_s2_valid;
    logic [COL_W-1:0]   r_s2_col;
    logic [ROW_W-1:0]   r_s2_row;
    logic               r_s2_first_col;
    logic               r_s2_last_col;
    logic               r_s2_last_row;
    logic               r_s2_has_mid;
    logic               s2_adv;
    t_result_set        res_set;
    logic [COORD_W-1:0] col_prev;
    logic [COORD_W-1:0] col_here;
    logic [COORD_W-1:0] row_prev;
    logic [COORD_W-1:0] row_here;

    logic               buf_can_take;
    t_result            out_res;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WDIM_W'(clamp_dim(CFG_W'(CFG_RESET), MAX_WIDTH));
            r_height <= HDIM_W'(clamp_dim(CFG_W'(CFG_RESET), MAX_HEIGHT));
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_GRID_WIDTH: begin
                    r_width <= WDIM_W'(clamp_dim(i_cfg_data, MAX_WIDTH));
                end
                CFG_GRID_HEIGHT: begin
                    r_height <= HDIM_W'(clamp_dim(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow: each stage moves when the one after it is free.
    assign s2_adv  = r_s2_valid && buf_can_take;
    assign s1_adv  = r_s1_valid && (!r_s2_valid || s2_adv);
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;

    // Raster position counters.
    assign last_col_in = (WDIM_W'(r_col) + WDIM_W'(1)) >= r_width;
    assign last_row_in = (HDIM_W'(r_row) + HDIM_W'(1)) >= r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col_in) begin
                r_col <= '0;
                r_row <= last_row_in ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Stage 1 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload, plus the forwarding capture for the row store.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur       <= i_cell_alive;
            r_s1_col       <= r_col;
            r_s1_row       <= r_row;
            r_s1_first_col <= (r_col == '0);
            r_s1_last_col  <= last_col_in;
            r_s1_last_row  <= last_row_in;
            r_s1_has_top   <= (r_row > ROW_W'(1));
            r_s1_has_mid   <= (r_row != '0);
            r_fwd_hit      <= s1_adv && (r_s1_col == r_col);
            r_fwd_word     <= store_wdata;
        end
    end

    // Row stores: both rows share one word per column.
    assign store_word  = r_fwd_hit ? r_fwd_word : ram_q;
    assign store_wdata = {store_word[0], r_s1_cur};
    assign top_bit     = r_s1_has_top && store_word[1];
    assign mid_bit     = r_s1_has_mid && store_word[0];

    lag_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (store_wdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // Window: the newest column enters at the right and moves one cell left
    // per cell request.
    assign win_col[WIN_COLS] = {r_s1_cur, mid_bit, top_bit};

    for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
        lag_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_adv),
            .i_clear (r_s1_first_col && (k != WIN_COLS - 1)),
            .i_col   (win_col[k + 1]),
            .o_col   (win_col[k])
        );
    end

    assign window = {win_col[2], win_col[1], win_col[0]};

    // Stage 2 control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_col       <= r_s1_col;
            r_s2_row       <= r_s1_row;
            r_s2_first_col <= r_s1_first_col;
            r_s2_last_col  <= r_s1_last_col;
            r_s2_last_row  <= r_s1_last_row;
            r_s2_has_mid   <= r_s1_has_mid;
        end
    end

    // Up to four results: the cell up and left, the cell above at a row end,
    // and in the last row the cell to the left and, at a row end, the cell
    // itself, with missing neighbors right and below read as dead.
    assign col_prev = COORD_W'(r_s2_col - COL_W'(1));
    assign col_here = COORD_W'(r_s2_col);
    assign row_prev = COORD_W'(r_s2_row - ROW_W'(1));
    assign row_here = COORD_W'(r_s2_row);

    always_comb begin
        res_set.mask[0] = r_s2_has_mid && !r_s2_first_col;
        res_set.mask[1] = r_s2_has_mid && r_s2_last_col;
        res_set.mask[2] = r_s2_last_row && !r_s2_first_col;
        res_set.mask[3] = r_s2_last_row && r_s2_last_col;

        res_set.slot[0] = '{alive: life_next(window),
                            col: col_prev, row: row_prev, last: 1'b0};
        res_set.slot[1] = '{alive: life_next({3'b000, window[8:3]}),
                            col: col_here, row: row_prev, last: 1'b0};
        res_set.slot[2] = '{alive: life_next({1'b0, window[8:7], 1'b0, window[5:4],
                                              1'b0, window[2:1]}),
                            col: col_prev, row: row_here, last: 1'b0};
        res_set.slot[3] = '{alive: life_next({4'b0000, window[8:7], 1'b0, window[5:4]}),
                            col: col_here, row: row_here, last: 1'b1};
    end

    // Output register stage that releases one result per cycle while i_ready is high.
    lag_result_buf u_result_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (s2_adv),
        .i_set      (res_set),
        .o_can_take (buf_can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_res)
    );

    assign o_next_alive = out_res.alive;
    assign o_cell_col   = out_res.col;
    assign o_cell_row   = out_res.row;
    assign o_gen_last   = out_res.last;

    // The last cell of a frame returns the counters to the origin.
    `LAG_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, accept && last_col_in && last_row_in, (r_col == '0) && (r_row == '0), "frame end did not wrap the position counters")

    // The window only moves together with a stage 1 transfer.
    `LAG_ASSERT_NEXT(a_window_hold, i_clk, i_rst_n, !s1_adv, $stable(window), "window changed without a stage 1 transfer")

    // A stage 2 item refused by the result buffer stays in place.
    `LAG_ASSERT_NEXT(a_s2_hold, i_clk, i_rst_n, r_s2_valid && !buf_can_take, r_s2_valid && $stable(r_s2_col) && $stable(r_s2_row), "stage 2 item lost while the result buffer was full")

endmodule
